[rtl/core/sgr_pkg.sv]
// Package for the swipe gesture recogniser: widths, codes, types and shared helpers.
`default_nettype none

package sgr_pkg;

    localparam int MAX_TOUCHES = 10;
    localparam int COORD_WIDTH = 12;
    localparam int CNT_W       = $clog2(MAX_TOUCHES + 1);
    localparam int FUNC_W      = 3;
    localparam int TAG_W       = 8;
    localparam int MASK_W      = 4;
    localparam int THR_W       = 12;
    localparam int COS_W       = 16;
    localparam int PH_W        = 3;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int CC_W        = 2 * COS_W;
    localparam int TT_W        = 2 * THR_W;
    localparam int COS_FRAC_SQ = 30;

    localparam int DIR_RIGHT = 0;
    localparam int DIR_LEFT  = 1;
    localparam int DIR_UP    = 2;
    localparam int DIR_DOWN  = 3;

    localparam logic [CNT_W-1:0]  TOUCHES_RESET   = CNT_W'(1);
    localparam logic [MASK_W-1:0] DIR_MASK_RESET  = MASK_W'(2);
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(12);
    localparam logic [COS_W-1:0]  COS_RESET       = COS_W'(31651);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BEGAN     = 3'd0,
        FUNC_MOVED     = 3'd1,
        FUNC_ENDED     = 3'd2,
        FUNC_CANCELLED = 3'd3,
        FUNC_RESET     = 3'd4
    } func_t;

    typedef enum logic [PH_W-1:0] {
        PH_POSSIBLE  = 3'd0,
        PH_BEGAN     = 3'd1,
        PH_CHANGED   = 3'd2,
        PH_ENDED     = 3'd3,
        PH_FAILED    = 3'd4,
        PH_CANCELLED = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        REG_TOUCHES   = 2'd0,
        REG_DIR_MASK  = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_COS       = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DIFF   = 3'd1,
        ST_SQUARE = 3'd2,
        ST_LENGTH = 3'd3,
        ST_SCALE  = 3'd4,
        ST_COMMIT = 3'd5
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  touches_required;
        logic [MASK_W-1:0] direction_mask;
        logic [THR_W-1:0]  move_threshold;
        logic [COS_W-1:0]  cos_half_angle;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic diff;
        logic square;
        logic length;
        logic scale;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    function automatic phase_t abort_phase(input phase_t ph, input phase_t running_to);
        phase_t res;
        res = ph;
        if (ph == PH_POSSIBLE)
        begin
            res = PH_FAILED;
        end
        else if (ph == PH_BEGAN || ph == PH_CHANGED)
        begin
            res = running_to;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sgr_regs.sv]
// Configuration register file of the swipe gesture recogniser with its APB-style port.
`default_nettype none

module sgr_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sgr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [sgr_pkg::DATA_W-1:0]    pwdata,
    output logic      [sgr_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output sgr_pkg::cfg_t                      cfg
);

    sgr_pkg::cfg_t     cfg_reg;
    sgr_pkg::cfg_t     cfg_next;
    sgr_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = sgr_pkg::reg_idx_t'(paddr[sgr_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                sgr_pkg::REG_TOUCHES:
                    cfg_next.touches_required = pwdata[sgr_pkg::CNT_W-1:0];
                sgr_pkg::REG_DIR_MASK:
                    cfg_next.direction_mask = pwdata[sgr_pkg::MASK_W-1:0];
                sgr_pkg::REG_THRESHOLD:
                    cfg_next.move_threshold = pwdata[sgr_pkg::THR_W-1:0];
                sgr_pkg::REG_COS:
                    cfg_next.cos_half_angle = pwdata[sgr_pkg::COS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sgr_pkg::REG_TOUCHES:
                prdata = sgr_pkg::DATA_W'(cfg_reg.touches_required);
            sgr_pkg::REG_DIR_MASK:
                prdata = sgr_pkg::DATA_W'(cfg_reg.direction_mask);
            sgr_pkg::REG_THRESHOLD:
                prdata = sgr_pkg::DATA_W'(cfg_reg.move_threshold);
            sgr_pkg::REG_COS:
                prdata = sgr_pkg::DATA_W'(cfg_reg.cos_half_angle);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touches_required <= sgr_pkg::TOUCHES_RESET;
            cfg_reg.direction_mask   <= sgr_pkg::DIR_MASK_RESET;
            cfg_reg.move_threshold   <= sgr_pkg::THRESHOLD_RESET;
            cfg_reg.cos_half_angle   <= sgr_pkg::COS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sgr_ctrl.sv]
// Controller state machine that sequences one event through the datapath.
`default_nettype none

module sgr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sgr_pkg::status_t status,
    output sgr_pkg::cmd_t         cmd
);

    sgr_pkg::state_t state_reg;
    sgr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sgr_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = sgr_pkg::ST_DIFF;
                end
            end
            sgr_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = sgr_pkg::ST_SQUARE;
            end
            sgr_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = sgr_pkg::ST_LENGTH;
            end
            sgr_pkg::ST_LENGTH:
            begin
                cmd.length = 1'b1;
                state_next = sgr_pkg::ST_SCALE;
            end
            sgr_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = sgr_pkg::ST_COMMIT;
            end
            sgr_pkg::ST_COMMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.commit = 1'b1;
                    state_next = sgr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgr_pkg::ST_IDLE;
            end
        endcase
    end

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !status.out_full)
        else $error("Result committed while the output register was still full.");

    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sgr_pkg::ST_COMMIT && status.out_full) |=>
        state_reg == sgr_pkg::ST_COMMIT)
        else $error("Controller left the commit state while the output was blocked.");

endmodule

`default_nettype wire

[rtl/core/sgr_dp.sv]
// Datapath: captured event, squared-distance arithmetic, gesture state and output register.
`default_nettype none

module sgr_dp #(
    parameter int COORD_W = sgr_pkg::COORD_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sgr_pkg::cmd_t               cmd,
    output sgr_pkg::status_t                 status,
    input  wire sgr_pkg::cfg_t               cfg,
    input  wire logic [sgr_pkg::FUNC_W-1:0]  func,
    input  wire logic [sgr_pkg::CNT_W-1:0]   touches_in_event,
    input  wire logic [sgr_pkg::CNT_W-1:0]   touches_held,
    input  wire logic [sgr_pkg::TAG_W-1:0]   touch_tag,
    input  wire logic [COORD_W-1:0]          touch_x,
    input  wire logic [COORD_W-1:0]          touch_y,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic      [sgr_pkg::PH_W-1:0]    gesture_state
);

    localparam int DW   = COORD_W + 1;
    localparam int SQW  = 2 * COORD_W;
    localparam int LW   = SQW + 1;
    localparam int CMPW = (LW > sgr_pkg::TT_W) ? LW : sgr_pkg::TT_W;
    localparam int RW   = sgr_pkg::CC_W + LW;
    localparam int CW1  = sgr_pkg::CNT_W + 1;

    sgr_pkg::func_t                func_reg;
    logic [sgr_pkg::CNT_W-1:0]     nev_reg;
    logic [sgr_pkg::CNT_W-1:0]     nheld_reg;
    logic [sgr_pkg::TAG_W-1:0]     tag_in_reg;
    logic [COORD_W-1:0]            x_reg;
    logic [COORD_W-1:0]            y_reg;
    logic signed [DW-1:0]          dx_reg;
    logic signed [DW-1:0]          dy_reg;
    logic [sgr_pkg::CC_W-1:0]      cc_reg;
    logic [sgr_pkg::TT_W-1:0]      tt_reg;
    logic [SQW-1:0]                dx2_reg;
    logic [SQW-1:0]                dy2_reg;
    logic [LW-1:0]                 len2_reg;
    logic                          below_reg;
    logic [RW-1:0]                 rhs_reg;

    logic signed [2*DW-1:0]        dx_prod;
    logic signed [2*DW-1:0]        dy_prod;
    logic [LW-1:0]                 len_sum;
    logic [RW-1:0]                 rhs_prod;

    sgr_pkg::phase_t               phase_reg;
    sgr_pkg::phase_t               phase_next;
    logic                          tv_reg;
    logic                          tv_next;
    logic [sgr_pkg::TAG_W-1:0]     tag_reg;
    logic [sgr_pkg::TAG_W-1:0]     tag_next;
    logic [COORD_W-1:0]            ax_reg;
    logic [COORD_W-1:0]            ax_next;
    logic [COORD_W-1:0]            ay_reg;
    logic [COORD_W-1:0]            ay_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [sgr_pkg::PH_W-1:0]      out_state_reg;

    logic                          count_ok;
    logic                          end_low;
    logic                          move_ok;
    logic                          fit_x;
    logic                          fit_y;
    logic                          hit_up;
    logic                          hit_down;
    logic                          hit_left;
    logic                          hit_right;
    sgr_pkg::phase_t               judged;

    assign dx_prod  = dx_reg * dx_reg;
    assign dy_prod  = dy_reg * dy_reg;
    assign len_sum  = LW'(dx2_reg) + LW'(dy2_reg);
    assign rhs_prod = RW'(cc_reg) * RW'(len2_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= sgr_pkg::func_t'(func);
            nev_reg    <= touches_in_event;
            nheld_reg  <= touches_held;
            tag_in_reg <= touch_tag;
            x_reg      <= touch_x;
            y_reg      <= touch_y;
        end
        if (cmd.diff)
        begin
            dx_reg <= $signed({1'b0, x_reg}) - $signed({1'b0, ax_reg});
            dy_reg <= $signed({1'b0, y_reg}) - $signed({1'b0, ay_reg});
            cc_reg <= sgr_pkg::CC_W'(cfg.cos_half_angle) * sgr_pkg::CC_W'(cfg.cos_half_angle);
            tt_reg <= sgr_pkg::TT_W'(cfg.move_threshold) * sgr_pkg::TT_W'(cfg.move_threshold);
        end
        if (cmd.square)
        begin
            dx2_reg <= dx_prod[SQW-1:0];
            dy2_reg <= dy_prod[SQW-1:0];
        end
        if (cmd.length)
        begin
            len2_reg  <= len_sum;
            below_reg <= CMPW'(len_sum) < CMPW'(tt_reg);
        end
        if (cmd.scale)
        begin
            rhs_reg <= rhs_prod;
        end
    end

    // A direction matches when its component has its sign (right, down: >= 0; up, left: <= 0)
    // and its square, scaled by 2^30, reaches cos^2 times the squared travel.
    assign fit_x     = RW'({dx2_reg, sgr_pkg::COS_FRAC_SQ'(0)}) >= rhs_reg;
    assign fit_y     = RW'({dy2_reg, sgr_pkg::COS_FRAC_SQ'(0)}) >= rhs_reg;
    assign hit_up    = cfg.direction_mask[sgr_pkg::DIR_UP]
                       && (dy_reg[DW-1] || dy_reg == '0) && fit_y;
    assign hit_down  = cfg.direction_mask[sgr_pkg::DIR_DOWN] && !dy_reg[DW-1] && fit_y;
    assign hit_left  = cfg.direction_mask[sgr_pkg::DIR_LEFT]
                       && (dx_reg[DW-1] || dx_reg == '0) && fit_x;
    assign hit_right = cfg.direction_mask[sgr_pkg::DIR_RIGHT] && !dx_reg[DW-1] && fit_x;

    always_comb
    begin
        if (len2_reg != '0 && (hit_up || hit_down || hit_left || hit_right))
        begin
            judged = sgr_pkg::PH_BEGAN;
        end
        else
        begin
            judged = sgr_pkg::PH_FAILED;
        end
    end

    assign count_ok = (CW1'(nheld_reg) + CW1'(nev_reg)) == CW1'(cfg.touches_required);
    assign end_low  = CW1'(nheld_reg) < (CW1'(nev_reg) + CW1'(cfg.touches_required));
    assign move_ok  = (nev_reg == cfg.touches_required) && tv_reg && (tag_in_reg == tag_reg);

    always_comb
    begin
        phase_next = phase_reg;
        tv_next    = tv_reg;
        tag_next   = tag_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        case (func_reg)
            sgr_pkg::FUNC_BEGAN:
            begin
                if (count_ok)
                begin
                    if (!tv_reg)
                    begin
                        phase_next = sgr_pkg::PH_POSSIBLE;
                        tv_next    = 1'b1;
                        tag_next   = tag_in_reg;
                        ax_next    = x_reg;
                        ay_next    = y_reg;
                    end
                end
                else
                begin
                    phase_next = sgr_pkg::abort_phase(phase_reg, sgr_pkg::PH_CANCELLED);
                    tv_next    = 1'b0;
                end
            end
            sgr_pkg::FUNC_MOVED:
            begin
                if (!move_ok)
                begin
                    phase_next = sgr_pkg::abort_phase(phase_reg, sgr_pkg::PH_CANCELLED);
                end
                else if (phase_reg == sgr_pkg::PH_POSSIBLE)
                begin
                    if (!below_reg)
                    begin
                        phase_next = judged;
                        ax_next    = x_reg;
                        ay_next    = y_reg;
                    end
                end
                else
                begin
                    if (phase_reg == sgr_pkg::PH_BEGAN || phase_reg == sgr_pkg::PH_CHANGED)
                    begin
                        phase_next = sgr_pkg::PH_CHANGED;
                    end
                    ax_next = x_reg;
                    ay_next = y_reg;
                end
            end
            sgr_pkg::FUNC_ENDED:
            begin
                if (end_low)
                begin
                    phase_next = sgr_pkg::abort_phase(phase_reg, sgr_pkg::PH_ENDED);
                    tv_next    = 1'b0;
                end
            end
            sgr_pkg::FUNC_CANCELLED:
            begin
                phase_next = sgr_pkg::abort_phase(phase_reg, sgr_pkg::PH_CANCELLED);
                tv_next    = 1'b0;
            end
            sgr_pkg::FUNC_RESET:
            begin
                phase_next = sgr_pkg::PH_POSSIBLE;
                tv_next    = 1'b0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sgr_pkg::PH_POSSIBLE;
            tv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit)
            begin
                phase_reg <= phase_next;
                tv_reg    <= tv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            tag_reg       <= tag_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            out_state_reg <= phase_next;
        end
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign gesture_state   = out_state_reg;

    a_result_follows_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("A result appeared without a commit.");

    a_phase_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(phase_reg) && $stable(tv_reg))
        else $error("Gesture state changed outside a commit.");

endmodule

`default_nettype wire

[rtl/core/swipe_gesture_recognizer_core.sv]
// Top level of the swipe gesture recogniser: register file, controller and datapath.
//
//  Channel   Direction  Handshake           Payload
//  event     in         in_valid/in_ready   func, touches_in_event, touches_held,
//                                           touch_tag, touch_x, touch_y
//  result    out        out_valid/out_ready gesture_state
//  config    in         APB psel/penable    paddr, pwdata, prdata
//
// After an event's transfer the difference, square, length, scale and commit steps
// run in turn; the result is registered at the commit step. A new event is taken
// the cycle after its predecessor commits, so the block takes no new event before
// it is through with the last one. A stalled result holds the commit step until
// the output register is free. Reset clears the gesture phase, tracking flag and
// output valid, returns the controller to idle and loads the configuration defaults.
`default_nettype none

module swipe_gesture_recognizer_core #(
    parameter int COORD_WIDTH = sgr_pkg::COORD_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sgr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [sgr_pkg::DATA_W-1:0]    pwdata,
    output logic      [sgr_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sgr_pkg::FUNC_W-1:0]    func,
    input  wire logic [sgr_pkg::CNT_W-1:0]     touches_in_event,
    input  wire logic [sgr_pkg::CNT_W-1:0]     touches_held,
    input  wire logic [sgr_pkg::TAG_W-1:0]     touch_tag,
    input  wire logic [COORD_WIDTH-1:0]        touch_x,
    input  wire logic [COORD_WIDTH-1:0]        touch_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sgr_pkg::PH_W-1:0]      gesture_state
);

    sgr_pkg::cfg_t    cfg;
    sgr_pkg::cmd_t    cmd;
    sgr_pkg::status_t status;

    sgr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sgr_dp #(
        .COORD_W (COORD_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg),
        .func             (func),
        .touches_in_event (touches_in_event),
        .touches_held     (touches_held),
        .touch_tag        (touch_tag),
        .touch_x          (touch_x),
        .touch_y          (touch_y),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .gesture_state    (gesture_state)
    );

endmodule

`default_nettype wire
